// File: src/rcsfp_pkg.sv
// Shared constants and types for the RC serial frame parser.
package rcsfp_pkg;

    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int CHAN_IDX_W = 4;
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 8;

    localparam logic [BYTE_W-1:0] FRAME_LEN  = 8'd32;
    localparam logic [BYTE_W-1:0] FRAME_TYPE = 8'h40;

    localparam logic [POS_W-1:0] POS_LENGTH = 5'd0;
    localparam logic [POS_W-1:0] POS_TYPE   = 5'd1;
    localparam logic [POS_W-1:0] SUM_END    = 5'd30;
    localparam logic [POS_W-1:0] POS_LAST   = 5'd31;

    localparam logic [WORD_W-1:0] CSUM_INIT     = 16'hFFFF;
    localparam logic [WORD_W-1:0] MIN_PULSE_RST = 16'd1000;
    localparam logic [WORD_W-1:0] MAX_PULSE_RST = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 8'd1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_TYPE     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    // Frame hand-off from the byte parser to the result burst engine.
    typedef struct packed {
        logic    start;
        logic    bank;
        status_t status;
    } burst_req_t;

endpackage

// File: src/rcsfp_chan_mem.sv
// Channel word store: one write port, one registered read port.
module rcsfp_chan_mem #(
    parameter int ADDR_W = 5,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read data until the next read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/rcsfp_parser.sv
// Byte parser: frame position, checksum, error tracking and channel word writes.
module rcsfp_parser #(
    parameter int CHANNELS = 14
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [rcsfp_pkg::BYTE_W-1:0] s_rx_byte,
    input  logic [rcsfp_pkg::WORD_W-1:0] min_pulse,
    input  logic [rcsfp_pkg::WORD_W-1:0] max_pulse,
    input  logic                      burst_busy,
    output logic                      wr_en,
    output logic [rcsfp_pkg::CHAN_IDX_W:0] wr_addr,
    output logic [rcsfp_pkg::WORD_W-1:0] wr_data,
    output rcsfp_pkg::burst_req_t     burst_req
);

    logic [rcsfp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [rcsfp_pkg::WORD_W-1:0] csum_reg, csum_next;
    logic [rcsfp_pkg::BYTE_W-1:0] low_reg, low_next;
    rcsfp_pkg::status_t           err_reg, err_next;
    logic                         bank_reg, bank_next;

    logic                         accept;
    logic [rcsfp_pkg::POS_W-1:0]  pos_sub;
    logic [rcsfp_pkg::CHAN_IDX_W-1:0] word_k;
    logic [rcsfp_pkg::WORD_W-1:0] word;
    logic                         is_word;
    logic                         word_checked;

    // Stall the closing byte until the previous burst has issued all reads.
    assign s_ready = !((pos_reg == rcsfp_pkg::POS_LAST) && burst_busy);
    assign accept  = s_valid && s_ready;

    assign pos_sub      = pos_reg - 5'd3;
    assign word_k       = pos_sub[rcsfp_pkg::POS_W-1:1];
    assign word         = {s_rx_byte, low_reg};
    assign is_word      = pos_reg[0] && (pos_reg > rcsfp_pkg::POS_TYPE)
                          && (pos_reg < rcsfp_pkg::SUM_END);
    assign word_checked = word_k < rcsfp_pkg::CHAN_IDX_W'(CHANNELS);

    assign wr_en   = accept && is_word && word_checked;
    assign wr_addr = {bank_reg, word_k};
    assign wr_data = word;

    always_comb begin
        pos_next  = pos_reg;
        csum_next = csum_reg;
        low_next  = low_reg;
        err_next  = err_reg;
        bank_next = bank_reg;
        burst_req = '{start: 1'b0, bank: bank_reg, status: err_reg};

        if (accept) begin
            pos_next = pos_reg + 5'd1;
            if (pos_reg < rcsfp_pkg::SUM_END) begin
                csum_next = csum_reg - {8'd0, s_rx_byte};
            end

            if (pos_reg == rcsfp_pkg::POS_LENGTH) begin
                if (s_rx_byte != rcsfp_pkg::FRAME_LEN && err_reg == rcsfp_pkg::ST_OK) begin
                    err_next = rcsfp_pkg::ST_LENGTH;
                end
            end else if (pos_reg == rcsfp_pkg::POS_TYPE) begin
                if (s_rx_byte != rcsfp_pkg::FRAME_TYPE && err_reg == rcsfp_pkg::ST_OK) begin
                    err_next = rcsfp_pkg::ST_TYPE;
                end
            end else if (!pos_reg[0]) begin
                low_next = s_rx_byte;
            end else if (is_word) begin
                if (word_checked && (word < min_pulse || word > max_pulse)
                        && err_reg == rcsfp_pkg::ST_OK) begin
                    err_next = rcsfp_pkg::ST_RANGE;
                end
            end else begin
                // Closing byte: settle the status, hand the frame over, restart.
                burst_req.start = 1'b1;
                if (word != csum_reg && err_reg == rcsfp_pkg::ST_OK) begin
                    burst_req.status = rcsfp_pkg::ST_CHECKSUM;
                end
                pos_next  = '0;
                csum_next = rcsfp_pkg::CSUM_INIT;
                low_next  = '0;
                err_next  = rcsfp_pkg::ST_OK;
                bank_next = !bank_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            csum_reg <= rcsfp_pkg::CSUM_INIT;
            low_reg  <= '0;
            err_reg  <= rcsfp_pkg::ST_OK;
            bank_reg <= 1'b0;
        end else begin
            pos_reg  <= pos_next;
            csum_reg <= csum_next;
            low_reg  <= low_next;
            err_reg  <= err_next;
            bank_reg <= bank_next;
        end
    end

endmodule

// File: src/rcsfp_burst.sv
// Result burst engine: reads the frame's channel words and drives the result channel.
module rcsfp_burst #(
    parameter int CHANNELS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rcsfp_pkg::burst_req_t         burst_req,
    output logic                          busy,
    output logic                          rd_en,
    output logic [rcsfp_pkg::CHAN_IDX_W:0] rd_addr,
    input  logic [rcsfp_pkg::WORD_W-1:0]  rd_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rcsfp_pkg::CHAN_IDX_W-1:0] m_channel_index,
    output logic [rcsfp_pkg::WORD_W-1:0]  m_channel_value,
    output logic [2:0]                    m_frame_status,
    output logic                          m_last_of_frame
);

    localparam logic [rcsfp_pkg::CHAN_IDX_W-1:0] IDX_LAST =
        rcsfp_pkg::CHAN_IDX_W'(CHANNELS - 1);

    logic               busy_reg, busy_next;
    logic [rcsfp_pkg::CHAN_IDX_W-1:0] idx_reg, idx_next;
    logic               bank_reg, bank_next;
    rcsfp_pkg::status_t status_reg, status_next;

    // Read stage: memory data lines up with these
    logic               s1_vld_reg, s1_vld_next;
    logic [rcsfp_pkg::CHAN_IDX_W-1:0] s1_idx_reg;
    rcsfp_pkg::status_t s1_status_reg;

    logic               out_vld_reg, out_vld_next;
    logic [rcsfp_pkg::CHAN_IDX_W-1:0] out_idx_reg;
    logic [rcsfp_pkg::WORD_W-1:0] out_val_reg;
    rcsfp_pkg::status_t out_status_reg;
    logic               out_last_reg;

    logic               s1_move;

    assign s1_move = s1_vld_reg && (!out_vld_reg || m_ready);
    assign rd_en   = busy_reg && (!s1_vld_reg || s1_move);
    assign rd_addr = {bank_reg, idx_reg};
    assign busy    = busy_reg;

    always_comb begin
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        bank_next   = bank_reg;
        status_next = status_reg;
        if (burst_req.start) begin
            busy_next   = 1'b1;
            idx_next    = '0;
            bank_next   = burst_req.bank;
            status_next = burst_req.status;
        end else if (rd_en) begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == IDX_LAST) begin
                busy_next = 1'b0;
            end
        end

        s1_vld_next = rd_en ? 1'b1 : (s1_move ? 1'b0 : s1_vld_reg);
        out_vld_next = s1_move ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        bank_reg   <= bank_next;
        status_reg <= status_next;
        if (rd_en) begin
            s1_idx_reg    <= idx_reg;
            s1_status_reg <= status_reg;
        end
        if (s1_move) begin
            out_idx_reg    <= s1_idx_reg;
            out_val_reg    <= rd_data;
            out_status_reg <= s1_status_reg;
            out_last_reg   <= (s1_idx_reg == IDX_LAST);
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_channel_index = out_idx_reg;
    assign m_channel_value = out_val_reg;
    assign m_frame_status  = out_status_reg;
    assign m_last_of_frame = out_last_reg;

endmodule

// File: src/rc_serial_frame_parser.sv
// Path: the closing byte starts a burst; each result passes the read stage and the output register.
// Throughput: a byte every cycle; the CHANNELS results of a frame follow at one per cycle,
// paced by the single read port of the channel store (two banks, one per frame in flight) and by m_ready.
// The closing byte of a frame waits only while the previous frame still has reads to issue.
// Reset: synchronous, active low; clears position, checksum, status, banks and valids,
// and loads min_pulse = 1000, max_pulse = 2000. The store itself is not cleared.
module rc_serial_frame_parser #(
    parameter int CHANNELS = 14
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rcsfp_pkg::BYTE_W-1:0]      s_rx_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rcsfp_pkg::CHAN_IDX_W-1:0]  m_channel_index,
    output logic [rcsfp_pkg::WORD_W-1:0]      m_channel_value,
    output logic [2:0]                        m_frame_status,
    output logic                              m_last_of_frame,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcsfp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcsfp_pkg::WORD_W-1:0]      cfg_data
);

    logic [rcsfp_pkg::WORD_W-1:0] min_pulse_reg, min_pulse_next;
    logic [rcsfp_pkg::WORD_W-1:0] max_pulse_reg, max_pulse_next;

    logic                         wr_en;
    logic [rcsfp_pkg::CHAN_IDX_W:0] wr_addr;
    logic [rcsfp_pkg::WORD_W-1:0] wr_data;
    logic                         rd_en;
    logic [rcsfp_pkg::CHAN_IDX_W:0] rd_addr;
    logic [rcsfp_pkg::WORD_W-1:0] rd_data;
    logic                         burst_busy;
    rcsfp_pkg::burst_req_t        burst_req;

    assign cfg_ready = 1'b1;

    always_comb begin
        min_pulse_next = min_pulse_reg;
        max_pulse_next = max_pulse_reg;
        if (cfg_valid) begin
            case (cfg_index)
                rcsfp_pkg::REG_MIN_PULSE: min_pulse_next = cfg_data;
                rcsfp_pkg::REG_MAX_PULSE: max_pulse_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pulse_reg <= rcsfp_pkg::MIN_PULSE_RST;
            max_pulse_reg <= rcsfp_pkg::MAX_PULSE_RST;
        end else begin
            min_pulse_reg <= min_pulse_next;
            max_pulse_reg <= max_pulse_next;
        end
    end

    rcsfp_parser #(
        .CHANNELS (CHANNELS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .min_pulse  (min_pulse_reg),
        .max_pulse  (max_pulse_reg),
        .burst_busy (burst_busy),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .burst_req  (burst_req)
    );

    rcsfp_chan_mem #(
        .ADDR_W (rcsfp_pkg::CHAN_IDX_W + 1),
        .DATA_W (rcsfp_pkg::WORD_W)
    ) u_chan_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rcsfp_burst #(
        .CHANNELS (CHANNELS)
    ) u_burst (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .burst_req       (burst_req),
        .busy            (burst_busy),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_channel_index (m_channel_index),
        .m_channel_value (m_channel_value),
        .m_frame_status  (m_frame_status),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule
